// File: design/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int unsigned RegW  = 16;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned TimeW = 32;

  typedef logic [RegW-1:0]  reg_val_t;
  typedef logic [IdxW-1:0]  reg_idx_t;
  typedef logic [TimeW-1:0] stamp_t;

  localparam reg_idx_t RegLongLimit    = 3'd0;
  localparam reg_idx_t RegSingleLimit  = 3'd1;
  localparam reg_idx_t RegGapMax       = 3'd2;
  localparam reg_idx_t RegGapMin       = 3'd3;
  localparam reg_idx_t RegRepeatSwitch = 3'd4;
  localparam reg_idx_t RegRepeatSlow   = 3'd5;
  localparam reg_idx_t RegRepeatFast   = 3'd6;

  localparam reg_val_t RstLongLimit    = 16'd1000;
  localparam reg_val_t RstSingleLimit  = 16'd400;
  localparam reg_val_t RstGapMax       = 16'd300;
  localparam reg_val_t RstGapMin       = 16'd100;
  localparam reg_val_t RstRepeatSwitch = 16'd1000;
  localparam reg_val_t RstRepeatSlow   = 16'd200;
  localparam reg_val_t RstRepeatFast   = 16'd20;

  typedef struct packed {
    logic   level;
    stamp_t now_ms;
  } in_word_t;

  typedef struct packed {
    logic single_click;
    logic double_click;
    logic long_click;
    logic repeat_pulse;
  } out_word_t;

endpackage

// File: design/button_click_classifier.sv
// ----------------------------------------------------------------------------
// button_click_classifier
// Single, double and long click detection with auto-repeat on a stamped
// button level stream.
// ----------------------------------------------------------------------------
//  channel  signals                          direction  payload
//  in       in_valid_i / in_ready_o          input      in_data_i  (in_word_t)
//  out      out_valid_o / out_ready_i        output     out_data_o (out_word_t)
//  cfg      cfg_we_i, cfg_idx_i, cfg_data_i  input      16-bit register value
//
//  one word per cycle while the output is not stalled; the result appears in the
//  cycle after the input word is taken, held in the single output register
//  state updates at the accept edge, so consecutive words chain directly
//  in_ready_o is low only while a result waits and out_ready_i is low
//  reset clears state and loads the register defaults
// ----------------------------------------------------------------------------
module button_click_classifier
  import bcc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o,
  input  logic      cfg_we_i,
  input  reg_idx_t  cfg_idx_i,
  input  reg_val_t  cfg_data_i
);

  typedef enum logic [1:0] {
    PhIdle     = 2'd0,
    PhPressed  = 2'd1,
    PhReleased = 2'd2,
    PhHolding  = 2'd3
  } phase_e;

  reg_val_t long_limit_q, single_limit_q, gap_max_q, gap_min_q;
  reg_val_t rep_switch_q, rep_slow_q, rep_fast_q;

  phase_e    phase_q, phase_d;
  stamp_t    click_stamp_q, click_stamp_d;
  logic      rep_active_q, rep_active_d;
  stamp_t    rep_stamp_q, rep_stamp_d;
  stamp_t    rep_start_q, rep_start_d;
  reg_val_t  rep_int_q, rep_int_d;
  logic      out_valid_q;
  out_word_t out_data_q;
  out_word_t res_d;

  logic   in_fire;
  stamp_t elapsed, rep_elapsed, press_elapsed;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign elapsed       = in_data_i.now_ms - click_stamp_q;
  assign rep_elapsed   = in_data_i.now_ms - rep_stamp_q;
  assign press_elapsed = in_data_i.now_ms - rep_start_q;

  always_comb begin
    phase_d       = phase_q;
    click_stamp_d = click_stamp_q;
    rep_active_d  = rep_active_q;
    rep_stamp_d   = rep_stamp_q;
    rep_start_d   = rep_start_q;
    rep_int_d     = rep_int_q;
    res_d         = '0;

    if (in_data_i.level) begin
      case (phase_q)
        PhIdle: begin
          click_stamp_d = in_data_i.now_ms;
          phase_d       = PhPressed;
        end
        PhPressed: begin
          if (elapsed > {16'd0, long_limit_q}) begin
            phase_d          = PhHolding;
            res_d.long_click = 1'b1;
          end
        end
        PhReleased: begin
          if (({16'd0, gap_min_q} < elapsed) && (elapsed < {16'd0, gap_max_q})) begin
            phase_d            = PhHolding;
            res_d.double_click = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      case (phase_q)
        PhPressed: begin
          if (elapsed > {16'd0, single_limit_q}) begin
            phase_d = PhIdle;
          end else begin
            click_stamp_d = in_data_i.now_ms;
            phase_d       = PhReleased;
          end
        end
        PhHolding: phase_d = PhIdle;
        PhReleased: begin
          if (elapsed > {16'd0, gap_max_q}) begin
            phase_d            = PhIdle;
            res_d.single_click = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (in_data_i.level) begin
      if (rep_active_q) begin
        if (rep_elapsed > {16'd0, rep_int_q}) begin
          rep_stamp_d        = in_data_i.now_ms;
          res_d.repeat_pulse = 1'b1;
          if (press_elapsed > {16'd0, rep_switch_q}) begin
            rep_int_d = rep_fast_q;
          end
        end
      end else begin
        rep_start_d  = in_data_i.now_ms;
        rep_int_d    = rep_slow_q;
        rep_active_d = 1'b1;
      end
    end else begin
      rep_active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_limit_q   <= RstLongLimit;
      single_limit_q <= RstSingleLimit;
      gap_max_q      <= RstGapMax;
      gap_min_q      <= RstGapMin;
      rep_switch_q   <= RstRepeatSwitch;
      rep_slow_q     <= RstRepeatSlow;
      rep_fast_q     <= RstRepeatFast;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLongLimit:    long_limit_q   <= cfg_data_i;
        RegSingleLimit:  single_limit_q <= cfg_data_i;
        RegGapMax:       gap_max_q      <= cfg_data_i;
        RegGapMin:       gap_min_q      <= cfg_data_i;
        RegRepeatSwitch: rep_switch_q   <= cfg_data_i;
        RegRepeatSlow:   rep_slow_q     <= cfg_data_i;
        RegRepeatFast:   rep_fast_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhIdle;
      click_stamp_q <= '0;
      rep_active_q  <= 1'b0;
      rep_stamp_q   <= '0;
      rep_start_q   <= '0;
      rep_int_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q       <= phase_d;
        click_stamp_q <= click_stamp_d;
        rep_active_q  <= rep_active_d;
        rep_stamp_q   <= rep_stamp_d;
        rep_start_q   <= rep_start_d;
        rep_int_q     <= rep_int_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= res_d;
    end
  end

  // at most one click kind per word
  a_click_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({out_data_q.single_click, out_data_q.double_click,
                              out_data_q.long_click}))
    else $error("more than one click kind flagged");

  // an accepted word always yields a result next cycle
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted word produced no result");

  // a release stops the repeat unit
  a_release_stops_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_data_i.level) |=> (!rep_active_q && !out_data_q.repeat_pulse))
    else $error("repeat still active after release");

  // double click only out of the released phase
  a_double_from_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (phase_q != PhReleased)) |=> !out_data_q.double_click)
    else $error("double click outside released phase");

endmodule

// File: sim/button_click_classifier_tb.sv
// ----------------------------------------------------------------------------
// button_click_classifier_tb
// Streams stamped button levels through the click classifier under random
// input bursts and output stalls. A local model of the click phases and the
// auto-repeat timer predicts the flags of every word, and each result word is
// checked flag by flag. Phases switch the timing registers between defaults,
// all zeros, all ones and random values while the block is drained.
// ----------------------------------------------------------------------------
module button_click_classifier_tb;
  import bcc_pkg::*;

  typedef enum logic [1:0] {PhIdle, PhPressed, PhReleased, PhHolding} click_phase_e;

  localparam reg_idx_t    RegNone      = 3'd7;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned PhaseZeros   = 1;
  localparam int unsigned PhaseOnes    = 2;
  localparam int unsigned RandPerPhase = 200;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;
  logic      cfg_we_i    = 1'b0;
  reg_idx_t  cfg_idx_i   = '0;
  reg_val_t  cfg_data_i  = '0;

  button_click_classifier u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // local copy of the registers and the classifier state
  reg_val_t     cfg_shadow [RegLongLimit:RegRepeatFast] = '{RstLongLimit, RstSingleLimit,
      RstGapMax, RstGapMin, RstRepeatSwitch, RstRepeatSlow, RstRepeatFast};
  click_phase_e click_phase  = PhIdle;
  stamp_t       click_stamp  = '0;
  logic         rep_active   = 1'b0;
  stamp_t       rep_stamp    = '0;
  stamp_t       rep_start    = '0;
  reg_val_t     rep_interval = '0;

  in_word_t    stim_q [$];
  out_word_t   flags_q [$];
  int unsigned words_queued = 0;
  int unsigned err_cnt      = 0;
  stamp_t      clock_ms     = '0;
  logic        in_took      = 1'b0;
  int unsigned idle_left    = 0;
  int unsigned burst_left   = 1;
  int unsigned rx_cyc       = 0;
  int unsigned rx_mode      = 0;

  function automatic out_word_t classify_update(in_word_t w);
    out_word_t r;
    stamp_t    el;
    stamp_t    since_pulse;
    stamp_t    since_start;
    r  = '0;
    el = w.now_ms - click_stamp;
    if (w.level) begin
      if (click_phase == PhIdle) begin
        click_stamp = w.now_ms;
        click_phase = PhPressed;
      end else if (click_phase == PhPressed && el > cfg_shadow[RegLongLimit]) begin
        click_phase  = PhHolding;
        r.long_click = 1'b1;
      end else if (click_phase == PhReleased && el > cfg_shadow[RegGapMin] &&
                   el < cfg_shadow[RegGapMax]) begin
        click_phase    = PhHolding;
        r.double_click = 1'b1;
      end
    end else if (click_phase != PhIdle) begin
      if (click_phase == PhPressed && el > cfg_shadow[RegSingleLimit]) begin
        click_phase = PhIdle;
      end else if (click_phase == PhPressed) begin
        click_stamp = w.now_ms;
        click_phase = PhReleased;
      end else if (click_phase == PhHolding) begin
        click_phase = PhIdle;
      end else if (el > cfg_shadow[RegGapMax]) begin
        click_phase    = PhIdle;
        r.single_click = 1'b1;
      end
    end

    // auto-repeat, independent of the click phase
    since_pulse = w.now_ms - rep_stamp;
    since_start = w.now_ms - rep_start;
    if (w.level) begin
      if (rep_active && since_pulse > rep_interval) begin
        rep_stamp      = w.now_ms;
        r.repeat_pulse = 1'b1;
        if (since_start > cfg_shadow[RegRepeatSwitch]) rep_interval = cfg_shadow[RegRepeatFast];
      end else if (!rep_active) begin
        rep_start    = w.now_ms;
        rep_interval = cfg_shadow[RegRepeatSlow];
        rep_active   = 1'b1;
      end
    end else begin
      rep_active = 1'b0;
    end
    return r;
  endfunction

  task automatic check_flag(string fname, logic got, logic want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0b, actual %0b", $time, fname, want, got);
      err_cnt++;
    end
  endtask

  // input acceptance feeds the model, output acceptance is checked
  always @(posedge clk_i) begin : monitor
    out_word_t want;
    in_took = rst_ni && in_valid_i && in_ready_o;
    if (in_took) flags_q.push_back(classify_update(in_data_i));
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (flags_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %b", $time, out_data_o);
        err_cnt++;
      end else begin
        want = flags_q.pop_front();
        check_flag("single_click", out_data_o.single_click, want.single_click);
        check_flag("double_click", out_data_o.double_click, want.double_click);
        check_flag("long_click",   out_data_o.long_click,   want.long_click);
        check_flag("repeat_pulse", out_data_o.repeat_pulse, want.repeat_pulse);
      end
    end
  end

  // sender: bursts of words with random gaps
  always @(negedge clk_i) begin
    if (!in_valid_i || in_took) begin
      if (idle_left != 0) begin
        idle_left--;
        in_valid_i <= 1'b0;
      end else if (stim_q.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= stim_q.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          if ($urandom_range(0, 15) == 0) idle_left = $urandom_range(10, 40);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall pattern picked anew at regular intervals, plus a periodic long hold-off
  always @(negedge clk_i) begin
    rx_cyc++;
    if (rx_cyc % 128 == 0) rx_mode = $urandom_range(0, 3);
    if (rx_cyc % 1500 >= 700 && rx_cyc % 1500 < 820) begin
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= ($urandom_range(0, 4) != 0);
        default: out_ready_i <= (rx_cyc % 3 != 0);
      endcase
    end
  end

  task automatic add_word(logic lvl, stamp_t ts);
    in_word_t w;
    w.level  = lvl;
    w.now_ms = ts;
    stim_q.push_back(w);
    words_queued++;
  endtask

  // time steps often land on a register value or one off it
  function automatic stamp_t pick_span();
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5:
        return stamp_t'(cfg_shadow[$urandom_range(RegLongLimit, RegRepeatFast)]) +
               $urandom_range(0, 2) - 1;
      6, 7, 8: return $urandom_range(0, 40);
      9, 10:   return $urandom_range(0, 2500);
      11:      return '0;
      12, 13:  return $urandom_range(1, 25);
      14:      return $urandom_range(0, 70000);
      default: return $urandom();
    endcase
  endfunction

  function automatic stamp_t pick_gap();
    if ($urandom_range(0, 3) == 0) return pick_span();
    if ($urandom_range(0, 2) == 0)
      return $urandom_range(cfg_shadow[RegGapMin], cfg_shadow[RegGapMax]);
    return stamp_t'($urandom_range(0, 1) ? cfg_shadow[RegGapMin] : cfg_shadow[RegGapMax]) +
           $urandom_range(0, 2) - 1;
  endfunction

  // press, held samples, release, optional second press, idle samples
  task automatic add_gesture();
    stamp_t      t_rel;
    int unsigned n;
    clock_ms += pick_span();
    add_word(1'b1, clock_ms);
    n = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 4);
    repeat (n) begin
      clock_ms += pick_span();
      add_word(1'b1, clock_ms);
    end
    clock_ms += pick_span();
    add_word(1'b0, clock_ms);
    t_rel = clock_ms;
    if ($urandom_range(0, 2) != 0) begin
      clock_ms = t_rel + pick_gap();
      add_word(1'b1, clock_ms);
      n = $urandom_range(0, 5);
      repeat (n) begin
        clock_ms += pick_span();
        add_word(1'b1, clock_ms);
      end
      clock_ms += pick_span();
      add_word(1'b0, clock_ms);
    end
    n = $urandom_range(0, 2);
    repeat (n) begin
      clock_ms += pick_span();
      add_word(1'b0, clock_ms);
    end
  endtask

  task automatic queue_random(int unsigned n_words);
    int unsigned goal;
    goal = words_queued + n_words;
    while (words_queued < goal) begin
      if ($urandom_range(0, 4) == 0) begin
        // noise: random level, random or drifting stamp
        if ($urandom_range(0, 1)) add_word(1'($urandom_range(0, 1)), $urandom());
        else begin
          clock_ms += pick_span();
          add_word(1'($urandom_range(0, 1)), clock_ms);
        end
      end else begin
        add_gesture();
      end
    end
  endtask

  task automatic wait_drained();
    while (stim_q.size() != 0 || in_valid_i || flags_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_t idx, reg_val_t val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx <= RegRepeatFast) cfg_shadow[idx] = val;
  endtask

  task automatic load_settings(int unsigned ph);
    reg_val_t v;
    for (int i = RegLongLimit; i <= RegRepeatFast; i++) begin
      if (ph == PhaseZeros) v = '0;
      else if (ph == PhaseOnes) v = '1;
      else begin
        case ($urandom_range(0, 6))
          0:       v = '0;
          1:       v = '1;
          2, 3, 4: v = 16'($urandom_range(0, 600));
          5:       v = 16'($urandom_range(0, 3000));
          default: v = 16'($urandom());
        endcase
      end
      write_reg(reg_idx_t'(i), v);
    end
    // unmapped index must leave every register alone
    if (ph == PhaseZeros) write_reg(RegNone, '1);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stim
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // default registers: long, single, dropped press, ignored press, double,
    // repeat switching to fast, wrap of the stamp
    add_word(1'b0, 32'd0);
    add_word(1'b1, 32'd100);
    add_word(1'b1, 32'd1100);
    add_word(1'b1, 32'd1101);
    add_word(1'b0, 32'd1200);
    add_word(1'b1, 32'd2000);
    add_word(1'b0, 32'd2400);
    add_word(1'b1, 32'd2500);
    add_word(1'b0, 32'd2700);
    add_word(1'b0, 32'd2701);
    add_word(1'b1, 32'd3000);
    add_word(1'b0, 32'd3401);
    add_word(1'b1, 32'd4000);
    add_word(1'b0, 32'd4100);
    add_word(1'b1, 32'd4201);
    add_word(1'b1, 32'd5500);
    add_word(1'b1, 32'd5521);
    add_word(1'b1, 32'd5542);
    add_word(1'b0, 32'd5600);
    add_word(1'b1, 32'hFFFF_FF00);
    add_word(1'b0, 32'h0000_0010);
    add_word(1'b0, 32'h0000_0150);
    add_word(1'b1, 32'hFFFF_FFFF);
    add_word(1'b0, 32'h0000_0000);
    clock_ms = 32'd10000;
    queue_random(RandPerPhase);

    for (int ph = 1; ph < NumPhases; ph++) begin
      wait_drained();
      load_settings(ph);
      clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 : $urandom();
      queue_random(RandPerPhase);
    end

    wait_drained();
    repeat (4) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("button_click_classifier verification clean");
    end else begin
      $display("button_click_classifier verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("button_click_classifier verification failed");
    $finish;
  end

endmodule
